// ===== src/page_frame_replacement_defines.svh =====
// assertion macros shared by the page frame replacement sources
`ifndef PAGE_FRAME_REPLACEMENT_DEFINES_SVH
`define PAGE_FRAME_REPLACEMENT_DEFINES_SVH

// checked on every clock edge outside reset
`define PFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define PFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/pfr_pkg.sv =====
// shared widths and hand-off records of the page frame replacement cells
package pfr_pkg;

  // frame index field, wide enough for the largest frame count supported
  localparam int unsigned IDX_W  = 6;
  // active frame count and fill pointer, as wide as the frame count register
  localparam int unsigned CNT_W  = 4;
  // recency rank, never above the active frame count minus one
  localparam int unsigned RANK_W = 4;

  // record that travels down the chain with one reference
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic              empty_found;
    logic [IDX_W-1:0]  empty_idx;
    logic [RANK_W-1:0] min_rank;
    logic [IDX_W-1:0]  min_idx;
    logic              vic_valid;
    logic [CNT_W-1:0]  cnt;
  } scan_t;

  // settings seen by every cell
  typedef struct packed {
    logic             lru;
    logic [CNT_W-1:0] act_n;
    logic [CNT_W-1:0] fifo_ptr;
  } ctl_t;

  // update broadcast to all cells when a reference commits
  typedef struct packed {
    logic              write;
    logic              touch;
    logic              dec;
    logic [IDX_W-1:0]  slot;
    logic [RANK_W-1:0] thr;
    logic [RANK_W-1:0] new_rank;
  } upd_t;

endpackage

// ===== src/page_frame_replacement.sv =====
// page frame replacement unit: lru and fifo policies over a chain of frame cells
//
// usage
//   s_axis carries one page reference per transaction (tdata = page_id).
//   m_axis returns one result per reference: tuser bit 0 hit, bit 1 evicted_valid;
//   tdata holds slot and the evicted page (zero when nothing was replaced).
//   the cfg channel writes register 0 (policy_mode) and 1 (frames_in_use);
//   cfg_ready_o is always high, writes are meant for an idle unit.
// flow
//   a reference enters cell 0 in its accept cycle and moves one cell per clock;
//   the record leaving the last cell is registered for the decide step, which
//   commits the update and loads the output register. s_axis_tready is high
//   only in idle, so the next reference waits until that commit.
// reset
//   all frames empty, ranks zero, fill pointer zero, lru policy, 8 frames.
// stalls
//   a result waiting on m_axis does not block the next reference; only when
//   the next scan ends with the output register still full does the unit wait
//   in the commit step until m_axis_tready frees it.
`include "page_frame_replacement_defines.svh"

module page_frame_replacement #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // reference in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((PAGE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // page_id
  // result out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // slot, evicted_page
  output logic [1:0]                           m_axis_tuser,  // hit, evicted_valid
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_index_i,
  input  logic [3:0]                           cfg_data_i
);
  import pfr_pkg::*;

  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgFrames = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  state_e               state_q;
  logic                 policy_q;
  logic [CNT_W-1:0]     frames_q;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     fifo_p;
  ctl_t                 ctl;
  upd_t                 upd, upd_bc;
  logic                 accept;
  logic                 commit;

  // result staging
  scan_t                fin_q;
  logic [PAGE_BITS-1:0] fin_page_q, fin_vic_q;
  logic [IDX_W-1:0]     res_slot;
  logic                 res_ev;
  logic [PAGE_BITS-1:0] res_evp;
  logic [31:0]          evp_ext;

  // output register
  logic                 m_valid_q;
  logic [23:0]          m_data_q;
  logic [1:0]           m_user_q;

  // chain wiring, entry g feeds cell g
  scan_t                chain_scan [FRAMES+1];
  logic [PAGE_BITS-1:0] chain_page [FRAMES+1];
  logic [PAGE_BITS-1:0] chain_vic  [FRAMES+1];
  logic [FRAMES-1:0]    in_flight;

  // active frame count: zero acts as one, clamp to the cells built
  always_comb begin
    if (frames_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(frames_q) > FRAMES) begin
      n_eff = CNT_W'(FRAMES);
    end else begin
      n_eff = frames_q;
    end
  end

  // a pointer left at or beyond the active count restarts at frame zero
  assign fifo_p = (fill_q >= n_eff) ? '0 : fill_q;

  assign ctl = '{lru: policy_q, act_n: n_eff, fifo_ptr: fifo_p};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // launch record for cell 0
  always_comb begin
    chain_scan[0]          = '0;
    chain_scan[0].valid    = accept;
    chain_scan[0].min_rank = '1;
  end
  assign chain_page[0] = s_axis_tdata[PAGE_BITS-1:0];
  assign chain_vic[0]  = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    pfr_cell #(
      .INDEX    (g),
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .upd_i      (upd_bc),
      .upd_page_i (fin_page_q),
      .scan_i     (chain_scan[g]),
      .page_i     (chain_page[g]),
      .vic_page_i (chain_vic[g]),
      .scan_o     (chain_scan[g+1]),
      .page_o     (chain_page[g+1]),
      .vic_page_o (chain_vic[g+1])
    );
    assign in_flight[g] = chain_scan[g+1].valid;
  end

  // decide slot, eviction and rank update from the finished scan
  always_comb begin
    upd      = '0;
    res_slot = fin_q.hit_idx;
    res_ev   = 1'b0;
    res_evp  = '0;
    fill_d   = fill_q;
    if (policy_q) begin
      upd.touch = 1'b1;
      if (fin_q.hit) begin
        // hit: ranks above the old one move down, this frame goes on top
        upd.dec      = 1'b1;
        upd.thr      = fin_q.hit_rank;
        upd.new_rank = fin_q.cnt - RANK_W'(1);
      end else if (fin_q.empty_found) begin
        res_slot     = fin_q.empty_idx;
        upd.write    = 1'b1;
        upd.new_rank = fin_q.cnt;
      end else begin
        // all active frames full: replace the least recent one
        res_slot     = fin_q.min_idx;
        upd.write    = 1'b1;
        upd.dec      = 1'b1;
        upd.thr      = fin_q.min_rank;
        upd.new_rank = fin_q.cnt - RANK_W'(1);
        res_ev       = 1'b1;
        res_evp      = fin_vic_q;
      end
    end else if (!fin_q.hit) begin
      res_slot  = IDX_W'(fifo_p);
      upd.write = 1'b1;
      res_ev    = fin_q.vic_valid;
      if (fin_q.vic_valid) begin
        res_evp = fin_vic_q;
      end
      fill_d = ((fifo_p + CNT_W'(1)) >= n_eff) ? '0 : (fifo_p + CNT_W'(1));
    end
    upd.slot = res_slot;
  end

  assign commit  = (state_q == ST_DECIDE) && (!m_valid_q || m_axis_tready);
  assign upd_bc  = commit ? upd : '0;
  assign evp_ext = 32'(res_evp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      policy_q   <= 1'b1;
      frames_q   <= CNT_W'(8);
      fill_q     <= '0;
      fin_q      <= '0;
      fin_page_q <= '0;
      fin_vic_q  <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgPolicy: policy_q <= cfg_data_i[0];
          CfgFrames: frames_q <= cfg_data_i;
          default:   policy_q <= policy_q;
        endcase
      end
      // a commit in the same cycle reloads the register instead
      if (m_valid_q && m_axis_tready && !commit) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain_scan[FRAMES].valid) begin
            fin_q      <= chain_scan[FRAMES];
            fin_page_q <= chain_page[FRAMES];
            fin_vic_q  <= chain_vic[FRAMES];
            state_q    <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (commit) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {5'd0, evp_ext[15:0], res_slot[2:0]};
            m_user_q  <= {res_ev, fin_q.hit};
            fill_q    <= fill_d;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // checks
  `PFR_ASSERT(a_one_ref_in_chain, ($countones(in_flight) <= 1), "more than one reference in the chain")
  `PFR_ASSERT(a_scan_end_in_scan, (chain_scan[FRAMES].valid |-> (state_q == ST_SCAN)), "scan ended outside the scan state")
  `PFR_ASSERT(a_fill_in_range, ((commit && !policy_q && !fin_q.hit) |=> (fill_q < n_eff)), "fill pointer out of range")
  `PFR_ASSERT(a_hit_no_evict, (m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1])), "hit reported with an eviction")
  `PFR_ASSERT_ALWAYS(a_chain_clear_in_reset, (!rst_ni |=> (in_flight == '0)), "chain not cleared by reset")

endmodule

// ===== src/pfr_cell.sv =====
// one page frame: holds page, valid and rank, and forwards the scan record
module pfr_cell #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfr_pkg::ctl_t         ctl_i,
  input  pfr_pkg::upd_t         upd_i,
  input  logic [PAGE_BITS-1:0]  upd_page_i,
  input  pfr_pkg::scan_t        scan_i,
  input  logic [PAGE_BITS-1:0]  page_i,
  input  logic [PAGE_BITS-1:0]  vic_page_i,
  output pfr_pkg::scan_t        scan_o,
  output logic [PAGE_BITS-1:0]  page_o,
  output logic [PAGE_BITS-1:0]  vic_page_o
);
  import pfr_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [RANK_W-1:0]    rank_q;
  logic                 active;
  logic                 mine;
  scan_t                scan_d, scan_q;
  logic [PAGE_BITS-1:0] vic_d, vic_q, fwd_q;

  assign active = (32'(ctl_i.act_n) > INDEX);
  assign mine   = (upd_i.slot == MyIdx);

  always_comb begin
    scan_d = scan_i;
    vic_d  = vic_page_i;
    if (scan_i.valid && active) begin
      if (valid_q && (page_q == page_i) && !scan_i.hit) begin
        scan_d.hit      = 1'b1;
        scan_d.hit_idx  = MyIdx;
        scan_d.hit_rank = rank_q;
      end
      if (!valid_q && !scan_i.empty_found) begin
        scan_d.empty_found = 1'b1;
        scan_d.empty_idx   = MyIdx;
      end
      if (valid_q) begin
        scan_d.cnt = scan_i.cnt + CNT_W'(1);
      end
      if (ctl_i.lru) begin
        // strict compare keeps the lowest index on a tie
        if (rank_q < scan_i.min_rank) begin
          scan_d.min_rank = rank_q;
          scan_d.min_idx  = MyIdx;
          vic_d           = page_q;
        end
      end else if (MyIdx == IDX_W'(ctl_i.fifo_ptr)) begin
        scan_d.vic_valid = valid_q;
        vic_d            = page_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      scan_q  <= '0;
    end else begin
      scan_q <= scan_d;
      if (upd_i.write && mine) begin
        valid_q <= 1'b1;
      end
      if (upd_i.touch) begin
        if (mine) begin
          rank_q <= upd_i.new_rank;
        end else if (active && valid_q && upd_i.dec && (rank_q > upd_i.thr)) begin
          rank_q <= rank_q - RANK_W'(1);
        end
      end
    end
  end

  // page contents are only read behind the valid bit
  always_ff @(posedge clk_i) begin
    if (upd_i.write && mine) begin
      page_q <= upd_page_i;
    end
    fwd_q <= page_i;
    vic_q <= vic_d;
  end

  assign scan_o     = scan_q;
  assign page_o     = fwd_q;
  assign vic_page_o = vic_q;

endmodule
